>>> hw/rtl/tlfs_pkg.sv
// Shared types and codes of the three-level feedback scheduler.
package tlfs_pkg;

    typedef logic [2:0] job_t;
    typedef logic [3:0] quota_t;
    typedef logic [3:0] runs_t;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_EXPIRE   = 2'd2,
        MODE_FINISH   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_ALL_DONE   = 3'd2,
        ST_REQUEUED   = 3'd3,
        ST_FINISHED   = 3'd4,
        ST_NO_CURRENT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        LV_HIGH   = 2'd0,
        LV_MEDIUM = 2'd1,
        LV_LOW    = 2'd2
    } level_t;

    typedef enum logic {
        CFG_HIGH_QUOTA   = 1'b0,
        CFG_MEDIUM_QUOTA = 1'b1
    } cfg_index_t;

    localparam quota_t HIGH_QUOTA_RESET   = 4'd2;
    localparam quota_t MEDIUM_QUOTA_RESET = 4'd4;
    localparam runs_t  RUNS_MAX           = 4'd15;

    // status of one ring as seen by the scheduler
    typedef struct packed {
        logic empty;
        logic full;
        job_t head;
    } ring_status_t;

endpackage

>>> hw/rtl/tlfs_ring.sv
// FIFO ring of job ids with a prefetched, registered head word.
module tlfs_ring #(
    parameter int DEPTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tlfs_pkg::job_t         push_data,
    input  logic                   pop,
    output tlfs_pkg::ring_status_t status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW:0]    tail_sum;
    logic [AW-1:0]  tail;
    logic           full, empty, do_push, do_pop;
    tlfs_pkg::job_t mem [DEPTH];
    tlfs_pkg::job_t head_data_reg;

    always_comb
    begin
        empty    = (count_reg == '0);
        full     = (count_reg == CW'(DEPTH));
        do_push  = push && !full;
        do_pop   = pop && !empty;
        tail_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
        if (tail_sum >= (AW + 1)'(DEPTH))
        begin
            tail_sum = tail_sum - (AW + 1)'(DEPTH);
        end
        tail = tail_sum[AW-1:0];

        head_next = head_reg;
        if (do_pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end

        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // read follows the next head; a word written to that slot is forwarded
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail] <= push_data;
        end
        if (do_push && (tail == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign status.empty = empty;
    assign status.full  = full;
    assign status.head  = head_data_reg;

endmodule

>>> hw/rtl/three_level_feedback_scheduler_top.sv
// Top level of the three-level feedback job scheduler.
// Takes one command word per cycle (load, dispatch, slice expired, finished) while out_ready
// lets the result register drain, and returns one result word per command: an input register,
// then one pass of ring-selection and per-job bookkeeping logic into the result register. Each
// ring keeps its head word prefetched from its memory, so back-to-back pops and push-then-pop
// need no bubble. Rings hold MAX_JOBS entries each; a push into a full ring is dropped. Quotas
// are written through the cfg channel (index 0 high quota, index 1 medium quota); the user must
// write them only while the block is idle, which the block itself does not enforce.
module three_level_feedback_scheduler_top #(
    parameter int MAX_JOBS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [2:0] job_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [2:0] job,
    output logic [1:0] level,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    // job ids are 3 bits wide, so at most eight jobs carry per-job state
    localparam int         JOB_SLOTS = (MAX_JOBS < 8) ? MAX_JOBS : 8;
    localparam int         JW        = $clog2(JOB_SLOTS);
    localparam logic [3:0] JOB_LIMIT = 4'(JOB_SLOTS);

    // input stage
    logic                s1_valid_reg;
    tlfs_pkg::mode_t     mode_reg;
    tlfs_pkg::job_t      job_id_reg;
    logic                proc_fire;

    // result stage
    logic                out_valid_reg;
    tlfs_pkg::status_t   status_reg, status_next;
    tlfs_pkg::job_t      job_reg, job_next;
    tlfs_pkg::level_t    level_reg, level_next;

    // scheduler state
    tlfs_pkg::quota_t    high_quota_reg, medium_quota_reg;
    logic                cur_valid_reg, cur_valid_next;
    tlfs_pkg::job_t      cur_job_reg, cur_job_next;
    tlfs_pkg::level_t    job_level_reg [JOB_SLOTS];
    tlfs_pkg::runs_t     high_runs_reg [JOB_SLOTS];
    tlfs_pkg::runs_t     medium_runs_reg [JOB_SLOTS];

    tlfs_pkg::ring_status_t hi_st, md_st, lo_st;
    logic                hi_push, md_push, lo_push;
    logic                hi_pop, md_pop, lo_pop;

    logic                id_ok;
    logic                got;
    tlfs_pkg::job_t      pop_job, sel_job, wr_job;
    tlfs_pkg::level_t    rd_level, lv_new;
    tlfs_pkg::runs_t     rd_hr, rd_mr, hr_inc, mr_inc;
    logic                push_req;
    tlfs_pkg::level_t    push_lv;
    logic                level_we, runs_we;
    tlfs_pkg::level_t    level_wdata;
    tlfs_pkg::runs_t     hr_wdata, mr_wdata;

    assign proc_fire = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || proc_fire;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        id_ok   = ({1'b0, job_id_reg} < JOB_LIMIT);
        got     = !hi_st.empty || !md_st.empty || !lo_st.empty;
        pop_job = !hi_st.empty ? hi_st.head : (!md_st.empty ? md_st.head : lo_st.head);
        sel_job = (mode_reg == tlfs_pkg::MODE_DISPATCH) ? pop_job : cur_job_reg;
        wr_job  = (mode_reg == tlfs_pkg::MODE_LOAD) ? job_id_reg : cur_job_reg;

        rd_level = job_level_reg[sel_job[JW-1:0]];
        rd_hr    = high_runs_reg[sel_job[JW-1:0]];
        rd_mr    = medium_runs_reg[sel_job[JW-1:0]];
        hr_inc   = (rd_hr == tlfs_pkg::RUNS_MAX) ? rd_hr : rd_hr + 1'b1;
        mr_inc   = (rd_mr == tlfs_pkg::RUNS_MAX) ? rd_mr : rd_mr + 1'b1;

        // run count and demotion on slice expiry
        hr_wdata = rd_hr;
        mr_wdata = rd_mr;
        case (rd_level)
            tlfs_pkg::LV_HIGH:
            begin
                hr_wdata = hr_inc;
                lv_new   = (hr_inc >= high_quota_reg) ? tlfs_pkg::LV_MEDIUM
                                                      : tlfs_pkg::LV_HIGH;
            end
            tlfs_pkg::LV_MEDIUM:
            begin
                mr_wdata = mr_inc;
                lv_new   = (mr_inc >= medium_quota_reg) ? tlfs_pkg::LV_LOW
                                                        : tlfs_pkg::LV_MEDIUM;
            end
            default:
            begin
                lv_new = tlfs_pkg::LV_LOW;
            end
        endcase

        status_next    = tlfs_pkg::ST_LOADED;
        job_next       = '0;
        level_next     = tlfs_pkg::LV_HIGH;
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        push_req       = 1'b0;
        push_lv        = tlfs_pkg::LV_HIGH;
        level_we       = 1'b0;
        runs_we        = 1'b0;
        level_wdata    = tlfs_pkg::LV_HIGH;
        hi_pop         = 1'b0;
        md_pop         = 1'b0;
        lo_pop         = 1'b0;

        unique case (mode_reg)
            tlfs_pkg::MODE_LOAD:
            begin
                status_next = tlfs_pkg::ST_LOADED;
                job_next    = job_id_reg;
                if (id_ok)
                begin
                    level_we = 1'b1;
                    runs_we  = 1'b1;
                    hr_wdata = '0;
                    mr_wdata = '0;
                    push_req = 1'b1;
                end
            end
            tlfs_pkg::MODE_DISPATCH:
            begin
                hi_pop = !hi_st.empty;
                md_pop = hi_st.empty && !md_st.empty;
                lo_pop = hi_st.empty && md_st.empty && !lo_st.empty;
                cur_valid_next = got;
                if (got)
                begin
                    cur_job_next = pop_job;
                    status_next  = tlfs_pkg::ST_DISPATCHED;
                    job_next     = pop_job;
                    level_next   = rd_level;
                end
                else
                begin
                    status_next = tlfs_pkg::ST_ALL_DONE;
                end
            end
            tlfs_pkg::MODE_EXPIRE:
            begin
                if (!cur_valid_reg)
                begin
                    status_next = tlfs_pkg::ST_NO_CURRENT;
                end
                else
                begin
                    cur_valid_next = 1'b0;
                    level_we       = 1'b1;
                    runs_we        = 1'b1;
                    level_wdata    = lv_new;
                    push_req       = 1'b1;
                    push_lv        = lv_new;
                    status_next    = tlfs_pkg::ST_REQUEUED;
                    job_next       = cur_job_reg;
                    level_next     = lv_new;
                end
            end
            tlfs_pkg::MODE_FINISH:
            begin
                if (!cur_valid_reg)
                begin
                    status_next = tlfs_pkg::ST_NO_CURRENT;
                end
                else
                begin
                    cur_valid_next = 1'b0;
                    status_next    = tlfs_pkg::ST_FINISHED;
                    job_next       = cur_job_reg;
                    level_next     = rd_level;
                end
            end
        endcase

        hi_push = proc_fire && push_req && (push_lv == tlfs_pkg::LV_HIGH);
        md_push = proc_fire && push_req && (push_lv == tlfs_pkg::LV_MEDIUM);
        lo_push = proc_fire && push_req && (push_lv == tlfs_pkg::LV_LOW);
        hi_pop  = proc_fire && hi_pop;
        md_pop  = proc_fire && md_pop;
        lo_pop  = proc_fire && lo_pop;
    end

    tlfs_ring #(.DEPTH(MAX_JOBS)) u_high_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hi_push),
        .push_data (wr_job),
        .pop       (hi_pop),
        .status    (hi_st)
    );

    tlfs_ring #(.DEPTH(MAX_JOBS)) u_medium_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (md_push),
        .push_data (wr_job),
        .pop       (md_pop),
        .status    (md_st)
    );

    tlfs_ring #(.DEPTH(MAX_JOBS)) u_low_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (lo_push),
        .push_data (wr_job),
        .pop       (lo_pop),
        .status    (lo_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            cur_valid_reg    <= 1'b0;
            cur_job_reg      <= '0;
            high_quota_reg   <= tlfs_pkg::HIGH_QUOTA_RESET;
            medium_quota_reg <= tlfs_pkg::MEDIUM_QUOTA_RESET;
            for (int i = 0; i < JOB_SLOTS; i++)
            begin
                job_level_reg[i]   <= tlfs_pkg::LV_HIGH;
                high_runs_reg[i]   <= '0;
                medium_runs_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (proc_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                cur_valid_reg <= cur_valid_next;
                cur_job_reg   <= cur_job_next;
                if (level_we)
                begin
                    job_level_reg[wr_job[JW-1:0]] <= level_wdata;
                end
                if (runs_we)
                begin
                    high_runs_reg[wr_job[JW-1:0]]   <= hr_wdata;
                    medium_runs_reg[wr_job[JW-1:0]] <= mr_wdata;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (tlfs_pkg::cfg_index_t'(cfg_index))
                    tlfs_pkg::CFG_HIGH_QUOTA:   high_quota_reg   <= cfg_data;
                    tlfs_pkg::CFG_MEDIUM_QUOTA: medium_quota_reg <= cfg_data;
                endcase
            end
        end
    end

    // payload words
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg   <= tlfs_pkg::mode_t'(mode);
            job_id_reg <= job_id;
        end
        if (proc_fire)
        begin
            status_reg <= status_next;
            job_reg    <= job_next;
            level_reg  <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign job       = job_reg;
    assign level     = level_reg;

    // expiry or finish always leaves no current job
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (mode_reg == tlfs_pkg::MODE_EXPIRE || mode_reg == tlfs_pkg::MODE_FINISH)
        |=> !cur_valid_reg)
    else $error("current job still valid after expiry or finish");

    // a dispatch makes a job current exactly when it reports one
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (mode_reg == tlfs_pkg::MODE_DISPATCH)
        |=> cur_valid_reg == (status_reg == tlfs_pkg::ST_DISPATCHED))
    else $error("current job does not match dispatch result");

    // a valid load always leaves the high ring non-empty
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (mode_reg == tlfs_pkg::MODE_LOAD) && id_ok |=> !hi_st.empty)
    else $error("high ring empty after load");

endmodule

>>> tb/sv/three_level_feedback_scheduler_top_test.sv
// Self-checking testbench for the three-level feedback scheduler top level.
`timescale 1ns / 100ps

module three_level_feedback_scheduler_top_test;

    localparam int JOBS        = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 292;

    typedef struct packed {
        tlfs_pkg::mode_t mode;
        tlfs_pkg::job_t  job_id;
    } sched_cmd_t;

    typedef struct packed {
        tlfs_pkg::status_t status;
        tlfs_pkg::job_t    job;
        tlfs_pkg::level_t  level;
    } sched_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] mode      = tlfs_pkg::MODE_LOAD;
    logic [2:0] job_id    = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic [2:0] job;
    logic [1:0] level;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = tlfs_pkg::CFG_HIGH_QUOTA;
    logic [3:0] cfg_data  = '0;

    three_level_feedback_scheduler_top #(
        .MAX_JOBS(JOBS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .job_id(job_id),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .job(job),
        .level(level),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // scheduler shadow state
    tlfs_pkg::job_t   ring_mem[3][JOBS];
    int unsigned      ring_head[3] = '{default: 0};
    int unsigned      ring_cnt[3]  = '{default: 0};
    tlfs_pkg::level_t lvl_of[JOBS] = '{default: tlfs_pkg::LV_HIGH};
    tlfs_pkg::runs_t  hi_runs[JOBS] = '{default: '0};
    tlfs_pkg::runs_t  md_runs[JOBS] = '{default: '0};
    bit               cur_ok = 1'b0;
    tlfs_pkg::job_t   cur_id = '0;
    tlfs_pkg::quota_t hi_quota = tlfs_pkg::HIGH_QUOTA_RESET;
    tlfs_pkg::quota_t md_quota = tlfs_pkg::MEDIUM_QUOTA_RESET;

    sched_cmd_t    pending_cmds[$];
    sched_result_t due_results[$];
    int            mismatch_cnt = 0;
    int            quiet_cycles = 0;
    int            gap_left = 0;
    int            burst_left = 0;
    logic [7:0]    stall_pat = 8'hFF;
    logic [5:0]    stall_age = '0;

    // a push into a full ring is dropped
    function automatic void ring_push(int l, tlfs_pkg::job_t id);
        if (ring_cnt[l] < JOBS)
        begin
            ring_mem[l][(ring_head[l] + ring_cnt[l]) % JOBS] = id;
            ring_cnt[l]++;
        end
    endfunction

    function automatic sched_result_t schedule_step(tlfs_pkg::mode_t op, tlfs_pkg::job_t id);
        sched_result_t    r;
        tlfs_pkg::job_t   j;
        tlfs_pkg::level_t lv;
        bit               got;
        r.status = tlfs_pkg::ST_LOADED;
        r.job    = '0;
        r.level  = tlfs_pkg::LV_HIGH;
        case (op)
            tlfs_pkg::MODE_LOAD:
            begin
                r.job       = id;
                lvl_of[id]  = tlfs_pkg::LV_HIGH;
                hi_runs[id] = '0;
                md_runs[id] = '0;
                ring_push(tlfs_pkg::LV_HIGH, id);
            end
            tlfs_pkg::MODE_DISPATCH:
            begin
                got = 1'b0;
                j   = '0;
                for (int l = 0; l < 3; l++)
                begin
                    if (!got && ring_cnt[l] != 0)
                    begin
                        j            = ring_mem[l][ring_head[l]];
                        ring_head[l] = (ring_head[l] + 1) % JOBS;
                        ring_cnt[l]--;
                        got          = 1'b1;
                    end
                end
                cur_ok = got;
                cur_id = j;
                if (got)
                begin
                    r.status = tlfs_pkg::ST_DISPATCHED;
                    r.job    = j;
                    r.level  = lvl_of[j];
                end
                else
                    r.status = tlfs_pkg::ST_ALL_DONE;
            end
            default:
            begin
                if (!cur_ok)
                    r.status = tlfs_pkg::ST_NO_CURRENT;
                else if (op == tlfs_pkg::MODE_EXPIRE)
                begin
                    j      = cur_id;
                    cur_ok = 1'b0;
                    lv     = lvl_of[j];
                    if (lv == tlfs_pkg::LV_HIGH)
                    begin
                        if (hi_runs[j] < tlfs_pkg::RUNS_MAX)
                            hi_runs[j]++;
                        if (hi_runs[j] >= hi_quota)
                            lv = tlfs_pkg::LV_MEDIUM;
                    end
                    else if (lv == tlfs_pkg::LV_MEDIUM)
                    begin
                        if (md_runs[j] < tlfs_pkg::RUNS_MAX)
                            md_runs[j]++;
                        if (md_runs[j] >= md_quota)
                            lv = tlfs_pkg::LV_LOW;
                    end
                    lvl_of[j] = lv;
                    ring_push(lv, j);
                    r.status  = tlfs_pkg::ST_REQUEUED;
                    r.job     = j;
                    r.level   = lv;
                end
                else
                begin
                    cur_ok   = 1'b0;
                    r.status = tlfs_pkg::ST_FINISHED;
                    r.job    = cur_id;
                    r.level  = lvl_of[cur_id];
                end
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // command sender: bursts of random length, random gaps in between
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        sched_cmd_t c;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                c = pending_cmds.pop_front();
                in_valid <= 1'b1;
                mode     <= c.mode;
                job_id   <= c.job_id;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: rotating stall mask, reloaded each time the 6-bit stall_age counter wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= stall_pat[0];
            stall_age <= stall_age + 1'b1;
            if (stall_age == 6'd63)
                stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom | 8'h01);
            else
                stall_pat <= {stall_pat[0], stall_pat[7:1]};
        end
    end

    // predict on each accepted command word, check each accepted result word
    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                due_results.push_back(schedule_step(tlfs_pkg::mode_t'(mode), job_id));
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    note_mismatch($sformatf("unexpected result status %0d job %0d level %0d",
                                            status, job, level));
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status || job !== want.job || level !== want.level)
                        note_mismatch($sformatf(
                            "result mismatch: exp status %0d job %0d level %0d, got %0d %0d %0d",
                            want.status, want.job, want.level, status, job, level));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** three_level_feedback_scheduler_top: FAILED **");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_cmd(tlfs_pkg::mode_t m, tlfs_pkg::job_t id);
        sched_cmd_t c;
        c.mode   = m;
        c.job_id = id;
        pending_cmds.push_back(c);
    endtask

    task automatic write_quota(tlfs_pkg::cfg_index_t idx, tlfs_pkg::quota_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == tlfs_pkg::CFG_HIGH_QUOTA)
            hi_quota = val;
        else
            md_quota = val;
        cfg_valid <= 1'b0;
    endtask

    // sampled between edges so that a word handed to the driver is never missed
    task automatic wait_idle();
        @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly dispatch followed by expiry or finish; loads keep the rings fed
    task automatic queue_random(int count);
        sched_cmd_t c;
        bit         holding;
        int         roll;
        holding = 1'b0;
        @(negedge clk);
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (holding)
                c.mode = (roll < 70) ? tlfs_pkg::MODE_EXPIRE :
                         (roll < 88) ? tlfs_pkg::MODE_FINISH :
                         (roll < 95) ? tlfs_pkg::MODE_DISPATCH : tlfs_pkg::MODE_LOAD;
            else
                c.mode = (roll < 40) ? tlfs_pkg::MODE_LOAD :
                         (roll < 88) ? tlfs_pkg::MODE_DISPATCH :
                         (roll < 94) ? tlfs_pkg::MODE_EXPIRE : tlfs_pkg::MODE_FINISH;
            c.job_id = tlfs_pkg::job_t'($urandom_range(0, JOBS - 1));
            holding  = (c.mode == tlfs_pkg::MODE_DISPATCH) ||
                       (holding && c.mode == tlfs_pkg::MODE_LOAD);
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        tlfs_pkg::quota_t hq_set[PHASES];
        tlfs_pkg::quota_t mq_set[PHASES];
        hq_set = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd15, 4'd1};
        mq_set = '{4'd1, 4'd15, 4'd0, 4'd7, 4'd1, 4'd15};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty scheduler, then fill the high ring past full
        push_cmd(tlfs_pkg::MODE_DISPATCH, 3'd0);
        push_cmd(tlfs_pkg::MODE_EXPIRE, 3'd0);
        push_cmd(tlfs_pkg::MODE_FINISH, 3'd7);
        for (int i = 0; i < JOBS; i++)
            push_cmd(tlfs_pkg::MODE_LOAD, tlfs_pkg::job_t'(i));
        push_cmd(tlfs_pkg::MODE_LOAD, 3'd5);
        push_cmd(tlfs_pkg::MODE_DISPATCH, 3'd0);
        push_cmd(tlfs_pkg::MODE_EXPIRE, 3'd0);
        push_cmd(tlfs_pkg::MODE_DISPATCH, 3'd0);
        push_cmd(tlfs_pkg::MODE_FINISH, 3'd0);
        // dispatch while a job is current drops the old one
        push_cmd(tlfs_pkg::MODE_DISPATCH, 3'd0);
        push_cmd(tlfs_pkg::MODE_DISPATCH, 3'd0);
        push_cmd(tlfs_pkg::MODE_EXPIRE, 3'd0);
        push_cmd(tlfs_pkg::MODE_DISPATCH, 3'd0);
        push_cmd(tlfs_pkg::MODE_EXPIRE, 3'd0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                hq_set[p] = tlfs_pkg::quota_t'($urandom_range(0, 15));
                mq_set[p] = tlfs_pkg::quota_t'($urandom_range(0, 15));
            end
            write_quota(tlfs_pkg::CFG_HIGH_QUOTA, hq_set[p]);
            write_quota(tlfs_pkg::CFG_MEDIUM_QUOTA, mq_set[p]);
            queue_random(PHASE_WORDS);
            wait_idle();
        end

        if (mismatch_cnt == 0 && due_results.size() == 0)
            $display("** three_level_feedback_scheduler_top: PASSED **");
        else
            $display("** three_level_feedback_scheduler_top: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tlfs_pkg.sv
hw/rtl/tlfs_ring.sv
hw/rtl/three_level_feedback_scheduler_top.sv
tb/sv/three_level_feedback_scheduler_top_test.sv
